// File: rtl/core/uatp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uatp_pkg
// Shared types and constants for the UTF-8 / ANSI terminal parser.
// ----------------------------------------------------------------------------
package uatp_pkg;

  localparam int TAB_STOP      = 8;
  localparam int MAX_ARGUMENTS = 8;
  localparam int ARG_IDX_W     = $clog2(MAX_ARGUMENTS);

  typedef logic [1:0]  action_t;
  typedef logic [20:0] codepoint_t;
  typedef logic [23:0] colour_t;
  typedef logic [15:0] arg_t;

  localparam action_t ACT_NONE  = 2'd0;
  localparam action_t ACT_DRAW  = 2'd1;
  localparam action_t ACT_CLEAR = 2'd2;

  localparam logic CFG_COLS = 1'b0;
  localparam logic CFG_ROWS = 1'b1;

  localparam logic [8:0] COLS_RESET = 9'd80;
  localparam logic [7:0] ROWS_RESET = 8'd25;

  localparam colour_t COL_GREY  = 24'hAAAAAA;
  localparam colour_t COL_WHITE = 24'hFFFFFF;
  localparam colour_t COL_BLACK = 24'h000000;

  // codepoints handled as controls
  localparam codepoint_t CP_NUL = 21'h00;
  localparam codepoint_t CP_BS  = 21'h08;
  localparam codepoint_t CP_TAB = 21'h09;
  localparam codepoint_t CP_LF  = 21'h0A;
  localparam codepoint_t CP_VT  = 21'h0B;
  localparam codepoint_t CP_FF  = 21'h0C;
  localparam codepoint_t CP_CR  = 21'h0D;
  localparam codepoint_t CP_ESC = 21'h1B;
  localparam codepoint_t CP_DEL = 21'h7F;

  // escape sequence bytes
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RIS      = 8'h63;
  localparam logic [7:0] CH_DIGIT0   = 8'h30;
  localparam logic [7:0] CH_DIGIT9   = 8'h39;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_CNL      = 8'h45;
  localparam logic [7:0] CH_CPL      = 8'h46;
  localparam logic [7:0] CH_CHA      = 8'h47;
  localparam logic [7:0] CH_CUP      = 8'h48;
  localparam logic [7:0] CH_HVP      = 8'h66;
  localparam logic [7:0] CH_ED       = 8'h4A;
  localparam logic [7:0] CH_SGR      = 8'h6D;

  localparam arg_t SGR_RESET   = 16'd0;
  localparam arg_t SGR_BOLD    = 16'd1;
  localparam arg_t SGR_FAINT   = 16'd2;
  localparam arg_t SGR_INVERSE = 16'd7;
  localparam arg_t SGR_FG_EXT  = 16'd38;
  localparam arg_t SGR_BG_EXT  = 16'd48;
  localparam arg_t SGR_RGB     = 16'd2;
  localparam arg_t ED_ALL      = 16'd2;
  localparam arg_t ARG_MAX     = 16'hFFFF;

endpackage
`default_nettype wire

// File: rtl/core/utf8_ansi_terminal_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_ansi_terminal_parser
// Byte-wide terminal front end: UTF-8 decode, ESC/CSI parsing, cursor and
// colour tracking; one command out per byte in.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | in_valid, in_stall, in_byte_in          | byte in
//  result  | out_valid, out_stall, out_action ...    | command out
//  config  | cfg_wr_en, cfg_index, cfg_data          | register write
//
//  One item per cycle when not stalled; the result appears the cycle after
//  acceptance, set by the single decode stage feeding the result register.
//  Synchronous active-low reset; no clearing pass, ready straight after reset.
//  in_stall is high only while a held result is stalled downstream.
// ----------------------------------------------------------------------------
module utf8_ansi_terminal_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_action,
  output logic [20:0]      out_codepoint,
  output logic [7:0]       out_draw_col,
  output logic [6:0]       out_draw_row,
  output logic [23:0]      out_fg_color,
  output logic [23:0]      out_bg_color,
  output logic [7:0]       out_cursor_col,
  output logic [6:0]       out_cursor_row,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [8:0]  cfg_data
);

  localparam int AW = uatp_pkg::ARG_IDX_W;
  localparam int NA = uatp_pkg::MAX_ARGUMENTS;
  localparam logic [AW-1:0] ARG_LAST = AW'(NA - 1);

  // configuration
  logic [8:0] cols_r;
  logic [7:0] rows_r;

  // parser state
  uatp_pkg::codepoint_t partial_r, partial_nxt;
  logic [1:0]           cont_r, cont_nxt;
  logic                 esc_active_r, esc_active_nxt;
  logic                 esc_csi_r, esc_csi_nxt;
  logic [AW-1:0]        arg_idx_r, arg_idx_nxt;
  uatp_pkg::arg_t       args_r [NA];
  uatp_pkg::arg_t       args_nxt [NA];
  logic [7:0]           col_r, col_nxt;
  logic [6:0]           row_r, row_nxt;
  uatp_pkg::colour_t    fg_r, fg_nxt;
  uatp_pkg::colour_t    bg_r, bg_nxt;

  // result register
  logic                 out_valid_r;
  uatp_pkg::action_t    action_r, action_nxt;
  uatp_pkg::codepoint_t cp_r, cp_nxt;
  logic [7:0]           dcol_r, dcol_nxt;
  logic [6:0]           drow_r, drow_nxt;

  logic accept;
  logic [7:0] max_col;
  logic [6:0] max_row;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign max_col = (cols_r == 9'd0) ? 8'd0 :
                   (cols_r > 9'd256) ? 8'd255 : 8'(cols_r - 9'd1);
  assign max_row = (rows_r == 8'd0) ? 7'd0 :
                   (rows_r > 8'd128) ? 7'd127 : 7'(rows_r - 8'd1);

  always_comb begin
    logic [19:0] acc;
    logic [7:0]  digit;
    logic [16:0] row_sum;
    logic [15:0] row_ext;
    logic [6:0]  row_down1;
    logic [8:0]  tab_pos;
    logic [1:0]  left_dec;
    logic        ready;
    uatp_pkg::codepoint_t shifted;
    uatp_pkg::colour_t    rgb;

    partial_nxt    = partial_r;
    cont_nxt       = cont_r;
    esc_active_nxt = esc_active_r;
    esc_csi_nxt    = esc_csi_r;
    arg_idx_nxt    = arg_idx_r;
    for (int i = 0; i < NA; i++) begin
      args_nxt[i] = args_r[i];
    end
    col_nxt    = col_r;
    row_nxt    = row_r;
    fg_nxt     = fg_r;
    bg_nxt     = bg_r;
    action_nxt = uatp_pkg::ACT_NONE;
    cp_nxt     = '0;
    dcol_nxt   = '0;
    drow_nxt   = '0;

    digit   = in_byte_in - uatp_pkg::CH_DIGIT0;
    acc     = ({4'd0, args_r[arg_idx_r]} << 3) + ({4'd0, args_r[arg_idx_r]} << 1)
              + {12'd0, digit};
    row_sum = {10'd0, row_r} + {1'b0, args_r[0]};
    row_ext = {9'd0, row_r};
    row_down1 = (row_r >= max_row) ? max_row : row_r + 7'd1;
    tab_pos = 9'(({1'b0, col_r} / 9'(uatp_pkg::TAB_STOP) + 9'd1)
              * 9'(uatp_pkg::TAB_STOP));
    rgb     = {args_r[4][7:0], args_r[3][7:0], args_r[2][7:0]};
    left_dec = cont_r - 2'd1;
    shifted  = '0;
    ready    = 1'b0;

    if (esc_active_r) begin
      if (!esc_csi_r) begin
        esc_active_nxt = 1'b0;
        if (in_byte_in == uatp_pkg::CH_LBRACKET) begin
          esc_csi_nxt    = 1'b1;
          esc_active_nxt = 1'b1;
        end else if (in_byte_in == uatp_pkg::CH_RIS) begin
          col_nxt    = '0;
          row_nxt    = '0;
          action_nxt = uatp_pkg::ACT_CLEAR;
        end
      end else if (in_byte_in >= uatp_pkg::CH_DIGIT0 && in_byte_in <= uatp_pkg::CH_DIGIT9) begin
        args_nxt[arg_idx_r] = (acc > {4'd0, uatp_pkg::ARG_MAX}) ? uatp_pkg::ARG_MAX : acc[15:0];
      end else if (in_byte_in == uatp_pkg::CH_SEMI) begin
        if (arg_idx_r < ARG_LAST) begin
          arg_idx_nxt = arg_idx_r + AW'(1);
        end
      end else begin
        esc_active_nxt = 1'b0;
        case (in_byte_in) inside
          uatp_pkg::CH_CNL: begin
            row_nxt = (row_sum > {10'd0, max_row}) ? max_row : row_sum[6:0];
            col_nxt = '0;
          end
          uatp_pkg::CH_CPL: begin
            row_nxt = (args_r[0] >= row_ext) ? 7'd0 : 7'(row_ext - args_r[0]);
            col_nxt = '0;
          end
          uatp_pkg::CH_CHA: begin
            col_nxt = (args_r[0] > {8'd0, max_col}) ? max_col : args_r[0][7:0];
          end
          uatp_pkg::CH_CUP, uatp_pkg::CH_HVP: begin
            col_nxt = (args_r[0] > {8'd0, max_col}) ? max_col : args_r[0][7:0];
            row_nxt = (args_r[1] > {9'd0, max_row}) ? max_row : args_r[1][6:0];
          end
          uatp_pkg::CH_ED: begin
            if (args_r[0] == uatp_pkg::ED_ALL) begin
              col_nxt    = '0;
              row_nxt    = '0;
              action_nxt = uatp_pkg::ACT_CLEAR;
            end
          end
          uatp_pkg::CH_SGR: begin
            if (args_r[0] == uatp_pkg::SGR_RESET) begin
              fg_nxt = uatp_pkg::COL_GREY;
              bg_nxt = uatp_pkg::COL_BLACK;
            end else if (args_r[0] == uatp_pkg::SGR_BOLD) begin
              fg_nxt = uatp_pkg::COL_WHITE;
            end else if (args_r[0] == uatp_pkg::SGR_FAINT) begin
              fg_nxt = uatp_pkg::COL_GREY;
            end else if (args_r[0] == uatp_pkg::SGR_INVERSE) begin
              fg_nxt = bg_r;
              bg_nxt = fg_r;
            end else if (args_r[0] == uatp_pkg::SGR_FG_EXT && args_r[1] == uatp_pkg::SGR_RGB) begin
              fg_nxt = rgb;
            end else if (args_r[0] == uatp_pkg::SGR_BG_EXT && args_r[1] == uatp_pkg::SGR_RGB) begin
              bg_nxt = rgb;
            end
          end
          default: ;
        endcase
      end
    end else begin
      // UTF-8 decode
      if (cont_r != 2'd0 && in_byte_in[7:6] == 2'b10) begin
        cont_nxt = left_dec;
        case (left_dec)
          2'd0:    shifted = {15'd0, in_byte_in[5:0]};
          2'd1:    shifted = {9'd0, in_byte_in[5:0], 6'd0};
          default: shifted = {3'd0, in_byte_in[5:0], 12'd0};
        endcase
        partial_nxt = partial_r | shifted;
        ready       = (left_dec == 2'd0);
      end else begin
        cont_nxt    = 2'd0;
        partial_nxt = {13'd0, in_byte_in};
        ready       = 1'b1;
        if (in_byte_in[7:5] == 3'b110) begin
          cont_nxt    = 2'd1;
          partial_nxt = {10'd0, in_byte_in[4:0], 6'd0};
          ready       = 1'b0;
        end else if (in_byte_in[7:4] == 4'b1110) begin
          cont_nxt    = 2'd2;
          partial_nxt = {5'd0, in_byte_in[3:0], 12'd0};
          ready       = 1'b0;
        end else if (in_byte_in[7:3] == 5'b11110) begin
          cont_nxt    = 2'd3;
          partial_nxt = {in_byte_in[2:0], 18'd0};
          ready       = 1'b0;
        end
      end

      if (ready) begin
        case (partial_nxt) inside
          uatp_pkg::CP_NUL, uatp_pkg::CP_DEL: ;
          uatp_pkg::CP_LF, uatp_pkg::CP_VT: begin
            col_nxt = '0;
            row_nxt = row_down1;
          end
          uatp_pkg::CP_BS: begin
            if (col_r != 8'd0) begin
              col_nxt = col_r - 8'd1;
            end
          end
          uatp_pkg::CP_CR: col_nxt = '0;
          uatp_pkg::CP_FF: begin
            col_nxt    = '0;
            row_nxt    = '0;
            action_nxt = uatp_pkg::ACT_CLEAR;
          end
          uatp_pkg::CP_TAB: begin
            col_nxt = (tab_pos > {1'b0, max_col}) ? max_col : tab_pos[7:0];
          end
          uatp_pkg::CP_ESC: begin
            esc_active_nxt = 1'b1;
            esc_csi_nxt    = 1'b0;
            arg_idx_nxt    = '0;
            for (int i = 0; i < NA; i++) begin
              args_nxt[i] = '0;
            end
          end
          default: begin
            action_nxt = uatp_pkg::ACT_DRAW;
            cp_nxt     = partial_nxt;
            dcol_nxt   = col_r;
            drow_nxt   = row_r;
            if (col_r >= max_col) begin
              col_nxt = '0;
              row_nxt = row_down1;
            end else begin
              col_nxt = col_r + 8'd1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r       <= uatp_pkg::COLS_RESET;
      rows_r       <= uatp_pkg::ROWS_RESET;
      partial_r    <= '0;
      cont_r       <= '0;
      esc_active_r <= 1'b0;
      esc_csi_r    <= 1'b0;
      arg_idx_r    <= '0;
      for (int i = 0; i < NA; i++) begin
        args_r[i] <= '0;
      end
      col_r        <= '0;
      row_r        <= '0;
      fg_r         <= uatp_pkg::COL_WHITE;
      bg_r         <= uatp_pkg::COL_BLACK;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          uatp_pkg::CFG_COLS: cols_r <= cfg_data;
          uatp_pkg::CFG_ROWS: rows_r <= cfg_data[7:0];
        endcase
      end
      if (accept) begin
        partial_r    <= partial_nxt;
        cont_r       <= cont_nxt;
        esc_active_r <= esc_active_nxt;
        esc_csi_r    <= esc_csi_nxt;
        arg_idx_r    <= arg_idx_nxt;
        for (int i = 0; i < NA; i++) begin
          args_r[i] <= args_nxt[i];
        end
        col_r        <= col_nxt;
        row_r        <= row_nxt;
        fg_r         <= fg_nxt;
        bg_r         <= bg_nxt;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      action_r <= action_nxt;
      cp_r     <= cp_nxt;
      dcol_r   <= dcol_nxt;
      drow_r   <= drow_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_action     = action_r;
  assign out_codepoint  = cp_r;
  assign out_draw_col   = dcol_r;
  assign out_draw_row   = drow_r;
  assign out_fg_color   = fg_r;
  assign out_bg_color   = bg_r;
  assign out_cursor_col = col_r;
  assign out_cursor_row = row_r;

endmodule
`default_nettype wire

// File: tb/tb_utf8_ansi_terminal_parser.sv
// ----------------------------------------------------------------------------
// tb_utf8_ansi_terminal_parser
// Self-checking bench for the byte-wide terminal parser. Bytes go in over the
// valid/stall channel. A behavioural copy of the decoder tracks the UTF-8
// assembly, the escape/CSI parsing, the cursor, the colours and the screen size,
// and predicts every command. Each command that comes out is compared
// field by field. Short directed tests come first, then randomised traffic.
// That traffic is mostly well-formed text, UTF-8 and CSI sequences, with some
// noise. It runs under several screen sizes and under changing idle and stall
// patterns.
// ----------------------------------------------------------------------------
module tb_utf8_ansi_terminal_parser;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int REPORT_CAP  = 40;

  localparam logic [7:0] B_NUL = uatp_pkg::CP_NUL[7:0];
  localparam logic [7:0] B_BS  = uatp_pkg::CP_BS[7:0];
  localparam logic [7:0] B_TAB = uatp_pkg::CP_TAB[7:0];
  localparam logic [7:0] B_LF  = uatp_pkg::CP_LF[7:0];
  localparam logic [7:0] B_VT  = uatp_pkg::CP_VT[7:0];
  localparam logic [7:0] B_FF  = uatp_pkg::CP_FF[7:0];
  localparam logic [7:0] B_CR  = uatp_pkg::CP_CR[7:0];
  localparam logic [7:0] B_ESC = uatp_pkg::CP_ESC[7:0];
  localparam logic [7:0] B_DEL = uatp_pkg::CP_DEL[7:0];

  typedef struct packed {
    uatp_pkg::action_t    action;
    uatp_pkg::codepoint_t cp;
    logic [7:0]           dcol;
    logic [6:0]           drow;
    uatp_pkg::colour_t    fg;
    uatp_pkg::colour_t    bg;
    logic [7:0]           ccol;
    logic [6:0]           crow;
  } term_cmd_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic [7:0]  in_byte_in = 8'h00;
  logic        out_stall  = 1'b0;
  logic        cfg_wr_en  = 1'b0;
  logic        cfg_index  = uatp_pkg::CFG_COLS;
  logic [8:0]  cfg_data   = 9'd0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  out_action;
  logic [20:0] out_codepoint;
  logic [7:0]  out_draw_col;
  logic [6:0]  out_draw_row;
  logic [23:0] out_fg_color;
  logic [23:0] out_bg_color;
  logic [7:0]  out_cursor_col;
  logic [6:0]  out_cursor_row;

  utf8_ansi_terminal_parser uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte_in     (in_byte_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_action     (out_action),
    .out_codepoint  (out_codepoint),
    .out_draw_col   (out_draw_col),
    .out_draw_row   (out_draw_row),
    .out_fg_color   (out_fg_color),
    .out_bg_color   (out_bg_color),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---- predictor state ----
  logic [8:0]        cols_reg = uatp_pkg::COLS_RESET;
  logic [7:0]        rows_reg = uatp_pkg::ROWS_RESET;
  int unsigned       utf_acc  = 0;
  int unsigned       utf_left = 0;
  bit                esc_on   = 1'b0;
  bit                esc_csi  = 1'b0;
  int unsigned       arg_sel  = 0;
  uatp_pkg::arg_t    args [uatp_pkg::MAX_ARGUMENTS];
  int unsigned       cur_col  = 0;
  int unsigned       cur_row  = 0;
  uatp_pkg::colour_t fg_now   = uatp_pkg::COL_WHITE;
  uatp_pkg::colour_t bg_now   = uatp_pkg::COL_BLACK;

  term_cmd_t   pending_cmds [$];
  logic [7:0]  burst [$];

  int idle_pct      = 0;
  int stall_pct     = 0;
  int items_sent    = 0;
  int cmds_checked  = 0;
  int draws_seen    = 0;
  int clears_seen   = 0;
  int config_writes = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;

  initial foreach (args[i]) args[i] = '0;

  function automatic int unsigned screen_cols();
    if (cols_reg == 9'd0) return 1;
    if (cols_reg > 9'd256) return 256;
    return 32'(cols_reg);
  endfunction

  function automatic int unsigned screen_rows();
    if (rows_reg == 8'd0) return 1;
    if (rows_reg > 8'd128) return 128;
    return 32'(rows_reg);
  endfunction

  function automatic int unsigned clamp_to(int unsigned v, int unsigned lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic void line_down(int unsigned n);
    cur_row = clamp_to(cur_row + n, screen_rows() - 1);
  endfunction

  function automatic void apply_attr();
    uatp_pkg::colour_t rgb;
    uatp_pkg::colour_t tmp;
    rgb = {args[4][7:0], args[3][7:0], args[2][7:0]};
    if (args[0] == uatp_pkg::SGR_RESET) begin
      fg_now = uatp_pkg::COL_GREY;
      bg_now = uatp_pkg::COL_BLACK;
    end else if (args[0] == uatp_pkg::SGR_BOLD) begin
      fg_now = uatp_pkg::COL_WHITE;
    end else if (args[0] == uatp_pkg::SGR_FAINT) begin
      fg_now = uatp_pkg::COL_GREY;
    end else if (args[0] == uatp_pkg::SGR_INVERSE) begin
      tmp    = fg_now;
      fg_now = bg_now;
      bg_now = tmp;
    end else if (args[0] == uatp_pkg::SGR_FG_EXT && args[1] == uatp_pkg::SGR_RGB) begin
      fg_now = rgb;
    end else if (args[0] == uatp_pkg::SGR_BG_EXT && args[1] == uatp_pkg::SGR_RGB) begin
      bg_now = rgb;
    end
  endfunction

  function automatic uatp_pkg::action_t escape_step(logic [7:0] b);
    int unsigned v;
    if (!esc_csi) begin
      esc_on = 1'b0;
      if (b == uatp_pkg::CH_LBRACKET) begin
        esc_csi = 1'b1;
        esc_on  = 1'b1;
      end else if (b == uatp_pkg::CH_RIS) begin
        cur_col = 0;
        cur_row = 0;
        return uatp_pkg::ACT_CLEAR;
      end
      return uatp_pkg::ACT_NONE;
    end
    if (b >= uatp_pkg::CH_DIGIT0 && b <= uatp_pkg::CH_DIGIT9) begin
      v = 32'(args[arg_sel]) * 10 + 32'(b - uatp_pkg::CH_DIGIT0);
      args[arg_sel] = (v > 32'(uatp_pkg::ARG_MAX)) ? uatp_pkg::ARG_MAX : v[15:0];
      return uatp_pkg::ACT_NONE;
    end
    if (b == uatp_pkg::CH_SEMI) begin
      if (arg_sel < uatp_pkg::MAX_ARGUMENTS - 1) arg_sel++;
      return uatp_pkg::ACT_NONE;
    end
    esc_on = 1'b0;
    case (b)
      uatp_pkg::CH_CNL: begin
        line_down(32'(args[0]));
        cur_col = 0;
      end
      uatp_pkg::CH_CPL: begin
        if (32'(args[0]) >= cur_row) cur_row = 0;
        else cur_row = cur_row - 32'(args[0]);
        cur_col = 0;
      end
      uatp_pkg::CH_CHA: cur_col = clamp_to(32'(args[0]), screen_cols() - 1);
      uatp_pkg::CH_CUP, uatp_pkg::CH_HVP: begin
        cur_col = clamp_to(32'(args[0]), screen_cols() - 1);
        cur_row = clamp_to(32'(args[1]), screen_rows() - 1);
      end
      uatp_pkg::CH_ED: begin
        if (args[0] == uatp_pkg::ED_ALL) begin
          cur_col = 0;
          cur_row = 0;
          return uatp_pkg::ACT_CLEAR;
        end
      end
      uatp_pkg::CH_SGR: apply_attr();
      default: ;
    endcase
    return uatp_pkg::ACT_NONE;
  endfunction

  function automatic term_cmd_t predict_command(logic [7:0] b);
    term_cmd_t            r;
    bit                   ready;
    uatp_pkg::codepoint_t u;
    r     = '0;
    ready = 1'b1;
    if (esc_on) begin
      r.action = escape_step(b);
    end else begin
      if (utf_left > 0 && b[7:6] == 2'b10) begin
        utf_left--;
        utf_acc |= 32'(b[5:0]) << (6 * utf_left);
        if (utf_left != 0) ready = 1'b0;
      end else begin
        utf_left = 0;
        utf_acc  = 32'(b);
        if (b >= 8'hC0 && b <= 8'hDF) begin
          utf_left = 1;
          utf_acc  = 32'(b[4:0]) << 6;
          ready    = 1'b0;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          utf_left = 2;
          utf_acc  = 32'(b[3:0]) << 12;
          ready    = 1'b0;
        end else if (b >= 8'hF0 && b <= 8'hF7) begin
          utf_left = 3;
          utf_acc  = 32'(b[2:0]) << 18;
          ready    = 1'b0;
        end
      end
      utf_acc &= 32'h1FFFFF;
      if (ready) begin
        u = utf_acc[20:0];
        case (u)
          uatp_pkg::CP_NUL, uatp_pkg::CP_DEL: ;
          uatp_pkg::CP_LF, uatp_pkg::CP_VT: begin
            cur_col = 0;
            line_down(1);
          end
          uatp_pkg::CP_BS: if (cur_col > 0) cur_col--;
          uatp_pkg::CP_CR: cur_col = 0;
          uatp_pkg::CP_FF: begin
            cur_col  = 0;
            cur_row  = 0;
            r.action = uatp_pkg::ACT_CLEAR;
          end
          uatp_pkg::CP_TAB: cur_col = clamp_to((cur_col / uatp_pkg::TAB_STOP + 1)
                                               * uatp_pkg::TAB_STOP, screen_cols() - 1);
          uatp_pkg::CP_ESC: begin
            esc_on  = 1'b1;
            esc_csi = 1'b0;
            arg_sel = 0;
            foreach (args[i]) args[i] = '0;
          end
          default: begin
            r.action = uatp_pkg::ACT_DRAW;
            r.cp     = u;
            r.dcol   = cur_col[7:0];
            r.drow   = cur_row[6:0];
            if (cur_col + 1 >= screen_cols()) begin
              cur_col = 0;
              line_down(1);
            end else begin
              cur_col++;
            end
          end
        endcase
      end
    end
    r.fg   = fg_now;
    r.bg   = bg_now;
    r.ccol = cur_col[7:0];
    r.crow = cur_row[6:0];
    return r;
  endfunction

  // ---- result checking ----
  function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t  %s: expected %h, got %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_results
    term_cmd_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cmds.size() == 0) begin
        mismatches++;
        $display("%0t  command with no byte waiting: action %h", $time, out_action);
      end else begin
        e = pending_cmds.pop_front();
        check_field("action",     24'(e.action), 24'(out_action));
        check_field("codepoint",  24'(e.cp),     24'(out_codepoint));
        check_field("draw_col",   24'(e.dcol),   24'(out_draw_col));
        check_field("draw_row",   24'(e.drow),   24'(out_draw_row));
        check_field("fg_color",   e.fg,          out_fg_color);
        check_field("bg_color",   e.bg,          out_bg_color);
        check_field("cursor_col", 24'(e.ccol),   24'(out_cursor_col));
        check_field("cursor_row", 24'(e.crow),   24'(out_cursor_row));
        cmds_checked++;
        if (e.action == uatp_pkg::ACT_DRAW) draws_seen++;
        if (e.action == uatp_pkg::ACT_CLEAR) clears_seen++;
      end
    end
  end

  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < stall_pct);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t  no traffic for %0d cycles, %0d commands outstanding",
               $time, QUIET_LIMIT, pending_cmds.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---- stimulus plumbing ----
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte_in <= b;
    do @(posedge clk); while (in_stall);
    pending_cmds.push_back(predict_command(b));
    items_sent++;
  endtask

  task automatic send_burst();
    while (burst.size() != 0) send_byte(burst.pop_front());
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_cmds.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [8:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == uatp_pkg::CFG_COLS) cols_reg = val;
    else rows_reg = val[7:0];
    config_writes++;
    @(posedge clk);
  endtask

  task automatic set_screen(input int unsigned cols, input int unsigned rows);
    wait_all_results();
    write_reg(uatp_pkg::CFG_COLS, 9'(cols));
    write_reg(uatp_pkg::CFG_ROWS, 9'(rows));
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 52; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 52; end
      default: begin idle_pct = 25; stall_pct = 25; end
    endcase
  endtask

  task automatic add_number(input int unsigned n);
    string s;
    s = $sformatf("%0d", n);
    for (int i = 0; i < s.len(); i++) burst.push_back(s[i]);
  endtask

  function automatic int unsigned random_arg();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom_range(0, 9);
      5, 6, 7:       return $urandom_range(0, 300);
      8:             return $urandom_range(0, 70000);
      default:       return $urandom_range(60000, 999999);
    endcase
  endfunction

  task automatic queue_csi();
    logic [7:0]  cmd;
    int unsigned nargs;
    burst.push_back(B_ESC);
    burst.push_back(uatp_pkg::CH_LBRACKET);
    case ($urandom_range(0, 8))
      0: cmd = uatp_pkg::CH_CNL;
      1: cmd = uatp_pkg::CH_CPL;
      2: cmd = uatp_pkg::CH_CHA;
      3: cmd = uatp_pkg::CH_CUP;
      4: cmd = uatp_pkg::CH_HVP;
      5: cmd = uatp_pkg::CH_ED;
      6, 7: cmd = uatp_pkg::CH_SGR;
      default: cmd = 8'($urandom_range(8'h40, 8'h7E));
    endcase
    if (cmd == uatp_pkg::CH_SGR && $urandom_range(0, 9) < 8) begin
      case ($urandom_range(0, 6))
        0: if ($urandom_range(0, 1) == 1) add_number(0);
        1: add_number(1);
        2: add_number(2);
        3: add_number(7);
        4, 5: begin
          add_number($urandom_range(0, 1) == 1 ? 38 : 48);
          burst.push_back(uatp_pkg::CH_SEMI);
          add_number($urandom_range(0, 5) == 0 ? 5 : 2);
          repeat (3) begin
            burst.push_back(uatp_pkg::CH_SEMI);
            add_number($urandom_range(0, 300));
          end
        end
        default: add_number(random_arg());
      endcase
    end else if (cmd == uatp_pkg::CH_ED && $urandom_range(0, 9) < 6) begin
      add_number(2);
    end else begin
      nargs = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 11) : $urandom_range(0, 3);
      for (int i = 0; i < nargs; i++) begin
        if (i > 0) burst.push_back(uatp_pkg::CH_SEMI);
        if ($urandom_range(0, 9) != 0) add_number(random_arg());
      end
    end
    burst.push_back(cmd);
  endtask

  task automatic queue_random_sequence();
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      repeat ($urandom_range(1, 40)) burst.push_back(8'($urandom_range(8'h20, 8'h7E)));
    end else if (kind < 35) begin
      case ($urandom_range(2, 4))
        2: burst.push_back({3'b110, 5'($urandom_range(0, 31))});
        3: burst.push_back({4'b1110, 4'($urandom_range(0, 15))});
        default: burst.push_back({5'b11110, 3'($urandom_range(0, 7))});
      endcase
      while (burst[0][7:6] == 2'b11 && burst.size() < 4 &&
             burst.size() <= ((burst[0][5] == 1'b0) ? 1 : (burst[0][4] == 1'b0) ? 2 : 3))
        burst.push_back({2'b10, 6'($urandom_range(0, 63))});
    end else if (kind < 45) begin
      case ($urandom_range(0, 8))
        0: burst.push_back(B_NUL);
        1: burst.push_back(B_BS);
        2: burst.push_back(B_TAB);
        3: burst.push_back(B_LF);
        4: burst.push_back(B_VT);
        5: burst.push_back(B_FF);
        6: burst.push_back(B_CR);
        7: burst.push_back(B_DEL);
        default: burst.push_back(8'($urandom_range(0, 31)));
      endcase
    end else if (kind < 75) begin
      queue_csi();
    end else if (kind < 82) begin
      burst.push_back(B_ESC);
      burst.push_back($urandom_range(0, 2) == 0 ? uatp_pkg::CH_RIS
                                                : 8'($urandom_range(0, 255)));
    end else if (kind < 90) begin
      burst.push_back(8'($urandom_range(8'hC0, 8'hF7)));
      if ($urandom_range(0, 1) == 1) burst.push_back({2'b10, 6'($urandom_range(0, 63))});
      burst.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) burst.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // ---- tests ----
  task automatic test_control_bytes();
    set_idling(0);
    burst = '{8'h41, B_NUL, B_DEL, B_TAB, B_BS, B_CR, B_BS, B_LF, B_VT, 8'h01, 8'h80, 8'hFF};
    send_burst();
  endtask

  task automatic test_utf8_decoding();
    set_idling(1);
    burst = '{8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'hE2, 8'h41};
    send_burst();
  endtask

  task automatic test_escape_sequences();
    set_idling(2);
    burst = '{B_ESC, uatp_pkg::CH_LBRACKET};
    add_number(99999);
    burst.push_back(uatp_pkg::CH_SEMI);
    add_number(99);
    burst.push_back(uatp_pkg::CH_CUP);
    burst.push_back(B_ESC);
    burst.push_back(uatp_pkg::CH_LBRACKET);
    add_number(7);
    burst.push_back(uatp_pkg::CH_SGR);
    burst.push_back(B_ESC);
    burst.push_back(uatp_pkg::CH_RIS);
    burst.push_back(B_FF);
    send_burst();
  endtask

  task automatic test_shrunk_screen();
    set_idling(3);
    burst = '{B_ESC, uatp_pkg::CH_LBRACKET};
    add_number(70);
    burst.push_back(uatp_pkg::CH_SEMI);
    add_number(20);
    burst.push_back(uatp_pkg::CH_CUP);
    send_burst();
    set_screen(10, 5);
    burst = '{B_TAB, 8'h79};
    send_burst();
  endtask

  task automatic test_random_traffic();
    int unsigned seg_cols [8] = '{80, 1, 256, 0, 3, 255, 0, 80};
    int unsigned seg_rows [8] = '{25, 1, 128, 0, 2, 127, 0, 25};
    int          seg_end;
    for (int seg = 0; seg < 8; seg++) begin
      if (seg_cols[seg] == 0) set_screen($urandom_range(1, 256), $urandom_range(1, 128));
      else set_screen(seg_cols[seg], seg_rows[seg]);
      set_idling(seg % 4);
      seg_end = items_sent + 165;
      while (items_sent < seg_end) begin
        queue_random_sequence();
        send_burst();
        if ($urandom_range(0, 199) == 0) wait_all_results();
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_control_bytes();
    test_utf8_decoding();
    test_escape_sequences();
    test_shrunk_screen();
    test_random_traffic();
    wait_all_results();
    repeat (4) @(posedge clk);
    $display("run: %0d bytes, %0d commands checked (%0d draws, %0d clears)",
             items_sent, cmds_checked, draws_seen, clears_seen);
    $display("run: %0d register writes across screen sizes 1x1 to 256x128, four idle/stall mixes",
             config_writes);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d field mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule
